>>> rtl/lph_pkg.sv
// Package for the linear-probe hash table: sizes, slot record type, codes, states.
// No dependencies; the core and the testbench import it.
`default_nettype none
package lph_pkg;
    localparam int MAX_SLOTS  = 256;
    localparam int MIN_SLOTS  = 8;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int HASH_BITS  = 32;

    localparam int SLOT_W = $clog2(MAX_SLOTS);   // slot index in one bank
    localparam int ADDR_W = SLOT_W + 1;          // bank bit plus slot index
    localparam int CAP_W  = SLOT_W + 1;          // holds MAX_SLOTS itself
    localparam int DEPTH  = 2 * MAX_SLOTS;

    typedef logic [1:0] t_mark;
    localparam t_mark MARK_EMPTY = 2'd0;
    localparam t_mark MARK_TOMB  = 2'd1;
    localparam t_mark MARK_USED  = 2'd2;

    typedef logic [1:0] t_req;
    localparam t_req REQ_GET    = 2'd0;
    localparam t_req REQ_SET    = 2'd1;
    localparam t_req REQ_REMOVE = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NOTFOUND = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

    typedef struct packed {
        t_mark                 mark;
        logic [KEY_BITS-1:0]   key;
        logic [HASH_BITS-1:0]  hash;
        logic [VALUE_BITS-1:0] value;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PRB_RD,
        S_PRB_CHK,
        S_RH_CLR,
        S_RH_RD,
        S_RH_CHK
    } t_state;
endpackage
`default_nettype wire

>>> rtl/lph_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/linear_probe_hash_table_core.sv
// Top level of the linear-probe hash table: request sequencer around one slot RAM.
// Depends on lph_pkg and lph_ram.
`default_nettype none
// Open-addressing hash table with linear probing and tombstones. A request is
// taken when start is high and busy is low; its one result appears on the
// o_ ports for a single cycle marked by o_valid, and cannot be held off.
// After reset the block sweeps all 512 slot entries to empty (busy high).
// Every probe step is an address state, then a check of the registered read
// data from the single slot RAM; requests answered without probing (empty
// table, full table, unknown type) are answered straight from idle. A set
// that grows the table first clears the new bank, then walks the old bank
// slot by slot, probing the new bank for each moved entry, then runs its own
// probe in the new bank.
module linear_probe_hash_table_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       i_req_type,
    input  wire logic [lph_pkg::KEY_BITS-1:0]     i_key,
    input  wire logic [lph_pkg::HASH_BITS-1:0]    i_key_hash,
    input  wire logic [lph_pkg::VALUE_BITS-1:0]   i_value,
    output logic                                  o_valid,
    output logic [1:0]                            o_status,
    output logic                                  o_is_new,
    output logic [lph_pkg::VALUE_BITS-1:0]        o_value_out
);
    import lph_pkg::*;

    function automatic logic [SLOT_W-1:0] cap_mask(input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] m;
        m = cap - CAP_W'(1);
        return m[SLOT_W-1:0];
    endfunction

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_ci, n_ci;
    t_req r_req, n_req;
    logic [KEY_BITS-1:0] r_key, n_key, r_mv_key, n_mv_key;
    logic [HASH_BITS-1:0] r_hash, n_hash, r_mv_hash, n_mv_hash;
    logic [VALUE_BITS-1:0] r_value, n_value, r_mv_value, n_mv_value;
    logic [CAP_W-1:0] r_cap, n_cap, r_ncap, n_ncap, r_live, n_live, r_i, n_i, r_n, n_n;
    logic r_bank, n_bank, r_rh, n_rh, r_have_tomb, n_have_tomb;
    logic [SLOT_W-1:0] r_idx, n_idx, r_tomb, n_tomb;
    logic r_valid, n_valid, r_is_new, n_is_new;
    t_status r_status, n_status;
    logic [VALUE_BITS-1:0] r_vout, n_vout;

    logic wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    t_slot wr_data, rd;
    logic [SLOT_BITS-1:0] ram_q;

    lph_ram #(.WIDTH(SLOT_BITS), .DEPTH(DEPTH)) u_slots (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(ram_q)
    );
    assign rd = t_slot'(ram_q);

    // probe context: main probe in the active bank, rehash probe in the other
    logic p_bank;
    logic [CAP_W-1:0] p_cap, idx_inc, n_inc;
    logic [KEY_BITS-1:0] p_key;
    logic [CAP_W+1:0] cap3;
    logic grow;
    logic [CAP_W:0] cap2;
    logic [CAP_W-1:0] grow_cap;
    logic f_done, f_found, f_hit;
    logic [SLOT_W-1:0] f_slot;

    assign p_bank  = r_rh ? ~r_bank : r_bank;
    assign p_cap   = r_rh ? r_ncap : r_cap;
    assign p_key   = r_rh ? r_mv_key : r_key;
    assign idx_inc = {1'b0, r_idx} + CAP_W'(1);
    assign n_inc   = r_n + CAP_W'(1);
    assign cap3    = {r_cap, 1'b0} + (CAP_W+2)'(r_cap);
    assign grow    = ({1'b0, r_live} + (CAP_W+1)'(1)) > {1'b0, cap3[CAP_W+1:2]};
    assign cap2    = {r_cap, 1'b0};
    always_comb begin
        if (r_cap < CAP_W'(MIN_SLOTS)) begin
            grow_cap = CAP_W'(MIN_SLOTS);
        end else if (cap2 > (CAP_W+1)'(MAX_SLOTS)) begin
            grow_cap = CAP_W'(MAX_SLOTS);
        end else begin
            grow_cap = cap2[CAP_W-1:0];
        end
    end

    // one probe step on the slot just read
    always_comb begin
        f_done  = 1'b0;
        f_found = 1'b0;
        f_hit   = 1'b0;
        f_slot  = r_idx;
        if (rd.mark == MARK_EMPTY) begin
            f_done  = 1'b1;
            f_found = 1'b1;
            f_slot  = r_have_tomb ? r_tomb : r_idx;
        end else if (rd.mark == MARK_USED && rd.key == p_key) begin
            f_done  = 1'b1;
            f_found = 1'b1;
            f_hit   = 1'b1;
        end else if (n_inc == p_cap) begin
            f_done  = 1'b1;
            f_found = r_have_tomb || rd.mark == MARK_TOMB;
            f_slot  = r_have_tomb ? r_tomb : r_idx;
        end
    end

    always_comb begin
        n_state = r_state;  n_ci = r_ci;  n_req = r_req;
        n_key = r_key;  n_hash = r_hash;  n_value = r_value;
        n_mv_key = r_mv_key;  n_mv_hash = r_mv_hash;  n_mv_value = r_mv_value;
        n_cap = r_cap;  n_ncap = r_ncap;  n_live = r_live;  n_i = r_i;  n_n = r_n;
        n_bank = r_bank;  n_rh = r_rh;  n_have_tomb = r_have_tomb;
        n_idx = r_idx;  n_tomb = r_tomb;
        n_valid = 1'b0;  n_status = ST_NOTFOUND;  n_is_new = 1'b0;  n_vout = '0;
        wr_en = 1'b0;  wr_addr = '0;  wr_data = rd;
        rd_en = 1'b0;  rd_addr = {p_bank, r_idx};

        unique case (r_state)
            S_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = r_ci;
                wr_data.mark = MARK_EMPTY;
                n_ci         = r_ci + ADDR_W'(1);
                if (r_ci == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req       = t_req'(i_req_type);
                    n_key       = i_key;
                    n_hash      = i_key_hash;
                    n_value     = i_value;
                    n_rh        = 1'b0;
                    n_n         = '0;
                    n_have_tomb = 1'b0;
                    n_idx       = i_key_hash[SLOT_W-1:0] & cap_mask(r_cap);
                    if (i_req_type == REQ_GET || i_req_type == REQ_REMOVE) begin
                        if (r_live == '0) begin
                            n_valid = 1'b1;
                        end else begin
                            n_state = S_PRB_RD;
                        end
                    end else if (i_req_type == REQ_SET) begin
                        if (!grow) begin
                            n_state = S_PRB_RD;
                        end else if (r_cap >= CAP_W'(MAX_SLOTS)) begin
                            n_valid  = 1'b1;
                            n_status = ST_FULL;
                        end else begin
                            n_ncap  = grow_cap;
                            n_i     = '0;
                            n_live  = '0;
                            n_state = S_RH_CLR;
                        end
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            S_RH_CLR: begin
                wr_en        = 1'b1;
                wr_addr      = {~r_bank, r_i[SLOT_W-1:0]};
                wr_data.mark = MARK_EMPTY;
                n_i          = r_i + CAP_W'(1);
                if (n_i == r_ncap) begin
                    n_i     = '0;
                    n_state = S_RH_RD;
                end
            end
            S_RH_RD: begin
                if (r_i == r_cap) begin
                    // walk done: switch banks and start the set's own probe
                    n_bank      = ~r_bank;
                    n_cap       = r_ncap;
                    n_rh        = 1'b0;
                    n_n         = '0;
                    n_have_tomb = 1'b0;
                    n_idx       = r_hash[SLOT_W-1:0] & cap_mask(r_ncap);
                    n_state     = S_PRB_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = {r_bank, r_i[SLOT_W-1:0]};
                    n_state = S_RH_CHK;
                end
            end
            S_RH_CHK: begin
                if (rd.mark == MARK_USED) begin
                    n_mv_key    = rd.key;
                    n_mv_hash   = rd.hash;
                    n_mv_value  = rd.value;
                    n_rh        = 1'b1;
                    n_n         = '0;
                    n_have_tomb = 1'b0;
                    n_idx       = rd.hash[SLOT_W-1:0] & cap_mask(r_ncap);
                    n_state     = S_PRB_RD;
                end else begin
                    n_i     = r_i + CAP_W'(1);
                    n_state = S_RH_RD;
                end
            end
            S_PRB_RD: begin
                rd_en   = 1'b1;
                n_state = S_PRB_CHK;
            end
            S_PRB_CHK: begin
                if (!f_done) begin
                    if (rd.mark == MARK_TOMB && !r_have_tomb) begin
                        n_have_tomb = 1'b1;
                        n_tomb      = r_idx;
                    end
                    n_idx   = (idx_inc == p_cap) ? '0 : idx_inc[SLOT_W-1:0];
                    n_n     = n_inc;
                    n_state = S_PRB_RD;
                end else if (r_rh) begin
                    if (f_found) begin
                        wr_en   = 1'b1;
                        wr_addr = {~r_bank, f_slot};
                        wr_data = '{mark: MARK_USED, key: r_mv_key, hash: r_mv_hash,
                                    value: r_mv_value};
                        n_live  = r_live + CAP_W'(1);
                    end
                    n_i     = r_i + CAP_W'(1);
                    n_state = S_RH_RD;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_req == REQ_SET) begin
                        if (f_found) begin
                            n_status = ST_OK;
                            wr_en    = 1'b1;
                            wr_addr  = {r_bank, f_slot};
                            wr_data  = '{mark: MARK_USED, key: r_key,
                                         hash: f_hit ? rd.hash : r_hash, value: r_value};
                            if (!f_hit) begin
                                n_live   = r_live + CAP_W'(1);
                                n_is_new = 1'b1;
                            end
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else if (f_hit) begin
                        n_status = ST_OK;
                        if (r_req == REQ_GET) begin
                            n_vout = rd.value;
                        end else begin
                            // remove: leave a tombstone, keep the count
                            wr_en        = 1'b1;
                            wr_addr      = {r_bank, r_idx};
                            wr_data.mark = MARK_TOMB;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ci    <= '0;
            r_cap   <= '0;
            r_live  <= '0;
            r_bank  <= 1'b0;
            r_valid <= 1'b0;
            r_rh    <= 1'b0;
            r_have_tomb <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ci    <= n_ci;
            r_cap   <= n_cap;
            r_live  <= n_live;
            r_bank  <= n_bank;
            r_valid <= n_valid;
            r_rh    <= n_rh;
            r_have_tomb <= n_have_tomb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;  r_key <= n_key;  r_hash <= n_hash;  r_value <= n_value;
        r_mv_key <= n_mv_key;  r_mv_hash <= n_mv_hash;  r_mv_value <= n_mv_value;
        r_ncap <= n_ncap;  r_i <= n_i;  r_n <= n_n;  r_idx <= n_idx;  r_tomb <= n_tomb;
        r_status <= n_status;  r_is_new <= n_is_new;  r_vout <= n_vout;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_is_new    = r_is_new;
    assign o_value_out = r_vout;

`ifndef ASSERT_OFF
    a_cap_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_cap))
        else $error("capacity not a power of two");
    a_live_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_live <= r_cap)
        else $error("count exceeds capacity");
    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_is_new |-> r_status == ST_OK && r_req == REQ_SET)
        else $error("is_new on a transaction that added nothing");
    a_no_wr_rd_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && rd_en |-> wr_addr != rd_addr)
        else $error("slot read and write collide");
`endif
endmodule
`default_nettype wire

>>> verif/linear_probe_hash_table_core_test.sv
// Self-checking testbench for linear_probe_hash_table_core: directed table, then random traffic.
// Checks results against typed rows or its table predictor; depends on lph_pkg and the rtl.
`default_nettype none
module linear_probe_hash_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lph_pkg::*;

    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct packed {
        t_req                  req;
        logic [KEY_BITS-1:0]   key;
        logic [HASH_BITS-1:0]  hash;
        logic [VALUE_BITS-1:0] value;
    } t_request;

    typedef struct packed {
        t_status               status;
        logic                  is_new;
        logic [VALUE_BITS-1:0] value;
    } t_answer;

    typedef struct packed {
        t_request rq;
        logic     typed;
        t_answer  want;
    } t_row;

    localparam logic [63:0] ONES = '1;
    localparam logic [31:0] HONES = '1;
    localparam t_req REQ_BAD = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_req_type;
    logic [KEY_BITS-1:0]   i_key;
    logic [HASH_BITS-1:0]  i_key_hash;
    logic [VALUE_BITS-1:0] i_value;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic                  o_is_new;
    logic [VALUE_BITS-1:0] o_value_out;

    linear_probe_hash_table_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_key(i_key), .i_key_hash(i_key_hash),
        .i_value(i_value), .o_valid(o_valid), .o_status(o_status),
        .o_is_new(o_is_new), .o_value_out(o_value_out)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: two banks of slots
    t_mark                 tbl_mark [DEPTH];
    logic [KEY_BITS-1:0]   tbl_key  [DEPTH];
    logic [HASH_BITS-1:0]  tbl_hash [DEPTH];
    logic [VALUE_BITS-1:0] tbl_val  [DEPTH];
    int unsigned           tbl_cap;
    int unsigned           tbl_count;
    int unsigned           tbl_bank;

    t_answer     pending_answers[$];
    int          error_count;
    int          idle_pct;
    longint      cycle_count;
    logic [63:0] pool_key [128];
    logic [31:0] pool_hash[128];

    function automatic bit find_slot(input int unsigned bk, input int unsigned cap,
                                     input logic [63:0] k, input logic [31:0] h,
                                     output int unsigned slot, output bit hit);
        int unsigned base;
        int unsigned i;
        int unsigned tomb;
        bit          seen_tomb;
        base = bk * MAX_SLOTS;
        seen_tomb = 0;
        tomb = 0;
        hit = 0;
        slot = 0;
        if (cap == 0) return 0;
        i = h % cap;
        for (int unsigned n = 0; n < cap; n++) begin
            if (tbl_mark[base + i] == MARK_EMPTY) begin
                slot = base + (seen_tomb ? tomb : i);
                return 1;
            end
            if (tbl_mark[base + i] == MARK_TOMB) begin
                if (!seen_tomb) begin
                    seen_tomb = 1;
                    tomb = i;
                end
            end else if (tbl_key[base + i] == k) begin
                slot = base + i;
                hit = 1;
                return 1;
            end
            i = (i + 1 == cap) ? 0 : i + 1;
        end
        slot = base + tomb;
        return seen_tomb;
    endfunction

    function automatic void grow_table(input int unsigned new_cap);
        int unsigned nb;
        int unsigned src;
        int unsigned dst;
        bit          hit;
        nb = tbl_bank ^ 1;
        for (int i = 0; i < MAX_SLOTS; i++) tbl_mark[nb * MAX_SLOTS + i] = MARK_EMPTY;
        tbl_count = 0;
        for (int unsigned i = 0; i < tbl_cap; i++) begin
            src = tbl_bank * MAX_SLOTS + i;
            if (tbl_mark[src] == MARK_USED &&
                find_slot(nb, new_cap, tbl_key[src], tbl_hash[src], dst, hit)) begin
                tbl_mark[dst] = MARK_USED;
                tbl_key[dst]  = tbl_key[src];
                tbl_hash[dst] = tbl_hash[src];
                tbl_val[dst]  = tbl_val[src];
                tbl_count++;
            end
        end
        tbl_bank = nb;
        tbl_cap = new_cap;
    endfunction

    function automatic t_answer apply_request(input t_request r);
        t_answer     a;
        int unsigned slot;
        int unsigned nc;
        bit          hit;
        bit          room;
        a = '{status: ST_NOTFOUND, is_new: 1'b0, value: '0};
        if (r.req == REQ_GET || r.req == REQ_REMOVE) begin
            if (tbl_count != 0 && find_slot(tbl_bank, tbl_cap, r.key, r.hash, slot, hit)
                && hit) begin
                a.status = ST_OK;
                if (r.req == REQ_GET) a.value = tbl_val[slot];
                else tbl_mark[slot] = MARK_TOMB;
            end
        end else if (r.req == REQ_SET) begin
            room = 1;
            if (tbl_count + 1 > tbl_cap * 3 / 4) begin
                if (tbl_cap >= MAX_SLOTS) begin
                    room = 0;
                end else begin
                    nc = (tbl_cap < MIN_SLOTS) ? MIN_SLOTS : tbl_cap * 2;
                    if (nc > MAX_SLOTS) nc = MAX_SLOTS;
                    grow_table(nc);
                end
            end
            if (room && find_slot(tbl_bank, tbl_cap, r.key, r.hash, slot, hit)) begin
                if (!hit) begin
                    tbl_mark[slot] = MARK_USED;
                    tbl_key[slot]  = r.key;
                    tbl_hash[slot] = r.hash;
                    tbl_count++;
                    a.is_new = 1'b1;
                end
                tbl_val[slot] = r.value;
                a.status = ST_OK;
            end else begin
                a.status = ST_FULL;
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h, expected %h (cycle %0d)", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // hold the transaction until busy is low at an edge, then record its outcome
    task automatic issue(input t_request r, input bit typed, input t_answer want);
        t_answer pred;
        start      <= 1'b1;
        i_req_type <= r.req;
        i_key      <= r.key;
        i_key_hash <= r.hash;
        i_value    <= r.value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = apply_request(r);
        pending_answers.push_back(typed ? want : pred);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_request random_request(input int pool_n, input bit fresh);
        t_request    r;
        int unsigned p;
        int unsigned pick;
        p = $urandom_range(pool_n - 1);
        pick = $urandom_range(99);
        r.key = pool_key[p];
        r.hash = pool_hash[p];
        r.value = {$urandom, $urandom};
        if (fresh || pick < 50) r.req = REQ_SET;
        else if (pick < 78) r.req = REQ_GET;
        else if (pick < 94) r.req = REQ_REMOVE;
        else r.req = REQ_BAD;
        if (fresh) begin
            r.key = {$urandom, $urandom};
            r.hash = $urandom;
        end else if ($urandom_range(19) == 0) begin
            // noise: a key most likely absent, any hash
            r.key = {$urandom, $urandom};
            r.hash = $urandom;
        end
        return r;
    endfunction

    t_row plan[20] = '{
        '{'{REQ_GET,    64'h0, 32'h0, 64'h0}, 1'b1, '{ST_NOTFOUND, 1'b0, 64'h0}},
        '{'{REQ_REMOVE, 64'h0, 32'h0, 64'h0}, 1'b1, '{ST_NOTFOUND, 1'b0, 64'h0}},
        '{'{REQ_BAD,    ONES,  HONES, ONES},  1'b1, '{ST_NOTFOUND, 1'b0, 64'h0}},
        '{'{REQ_SET,    64'h0, 32'h0, 64'h1}, 1'b1, '{ST_OK, 1'b1, 64'h0}},
        '{'{REQ_SET,    64'h0, 32'h0, 64'h2}, 1'b1, '{ST_OK, 1'b0, 64'h0}},
        '{'{REQ_GET,    64'h0, 32'h0, 64'h0}, 1'b1, '{ST_OK, 1'b0, 64'h2}},
        '{'{REQ_SET,    ONES,  HONES, ONES},  1'b1, '{ST_OK, 1'b1, 64'h0}},
        '{'{REQ_GET,    ONES,  HONES, 64'h0}, 1'b1, '{ST_OK, 1'b0, ONES}},
        '{'{REQ_SET,    64'h5, 32'h0, 64'h55}, 1'b0, '0},
        '{'{REQ_SET,    64'h6, 32'h8, 64'h66}, 1'b0, '0},
        '{'{REQ_GET,    64'h6, 32'h8, 64'h0}, 1'b0, '0},
        '{'{REQ_REMOVE, 64'h5, 32'h0, 64'h0}, 1'b0, '0},
        '{'{REQ_GET,    64'h6, 32'h8, 64'h0}, 1'b0, '0},
        '{'{REQ_SET,    64'h7, 32'h10, 64'h77}, 1'b0, '0},
        '{'{REQ_SET,    64'h8, 32'h7, 64'h88}, 1'b0, '0},
        '{'{REQ_SET,    64'h9, 32'h7, 64'h99}, 1'b0, '0},
        '{'{REQ_SET,    64'hA, 32'h3, 64'hAA}, 1'b0, '0},
        '{'{REQ_GET,    64'h9, 32'h7, 64'h0}, 1'b0, '0},
        '{'{REQ_REMOVE, 64'h0, 32'h0, 64'h0}, 1'b1, '{ST_OK, 1'b0, 64'h0}},
        '{'{REQ_GET,    64'h0, 32'h0, 64'h0}, 1'b1, '{ST_NOTFOUND, 1'b0, 64'h0}}
    };

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result", {62'd0, o_status}, 64'd0);
            end else begin
                want = pending_answers.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", {62'd0, o_status}, {62'd0, want.status});
                if (o_is_new != want.is_new)
                    report_mismatch("is_new", {63'd0, o_is_new}, {63'd0, want.is_new});
                if (o_value_out != want.value)
                    report_mismatch("value_out", o_value_out, want.value);
            end
        end
    end

    initial begin
        int pool_n;
        cycle_count = 0;
        error_count = 0;
        idle_pct = 0;
        for (int i = 0; i < DEPTH; i++) tbl_mark[i] = MARK_EMPTY;
        tbl_cap = 0;
        tbl_count = 0;
        tbl_bank = 0;
        for (int i = 0; i < 128; i++) begin
            pool_key[i] = {$urandom, $urandom};
            // collide on purpose for part of the pool
            pool_hash[i] = (i % 3 == 0) ? $urandom_range(7) : $urandom;
        end
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req_type <= REQ_GET;
        i_key      <= '0;
        i_key_hash <= '0;
        i_value    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) issue(plan[n].rq, plan[n].typed, plan[n].want);
        wait_drained();

        // four traffic phases; the pool widens so that the table keeps growing
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  pool_n = 12;  end
                1: begin idle_pct = 74; pool_n = 40;  end
                2: begin idle_pct = 0;  pool_n = 128; end
                default: begin idle_pct = 11; pool_n = 128; end
            endcase
            for (int n = 0; n < 240; n++)
                issue(random_request(pool_n, 1'b0), 1'b0, '0);
            if (ph == 3) begin
                // fill with fresh keys so that sets come to report full
                for (int n = 0; n < 230; n++)
                    issue(random_request(pool_n, 1'b1), 1'b0, '0);
                for (int n = 0; n < 40; n++)
                    issue(random_request(pool_n, 1'b0), 1'b0, '0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
